// ===== hw/rtl/tap_tempo_to_wiper_macros.svh =====
// ----------------------------------------------------------------------------
// Tap tempo assertion macros
// Short forms for the concurrent checks on the tap tempo block's ports.
// ----------------------------------------------------------------------------
`ifndef TAP_TEMPO_TO_WIPER_MACROS_SVH
`define TAP_TEMPO_TO_WIPER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define TTW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tap tempo port check failed");

// Next-cycle implication that stays active during reset.
`define TTW_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tap tempo port check failed");

`endif

// ===== hw/rtl/ttw_pkg.sv =====
// ----------------------------------------------------------------------------
// Tap tempo package
// Word types, register indexes, microcode and the tempo table.
// ----------------------------------------------------------------------------
package ttw_pkg;

  typedef struct packed {
    logic button_pressed;
    logic ms_tick;
  } in_word_t;

  typedef struct packed {
    logic        event_kind;
    logic [7:0]  wiper_position;
    logic [15:0] beat_ms;
    logic [10:0] divided_ms;
  } out_word_t;

  localparam logic EVENT_TAP  = 1'b0;
  localparam logic EVENT_SAVE = 1'b1;

  typedef logic [1:0]  cfg_addr_t;
  typedef logic [16:0] cfg_data_t;

  localparam cfg_addr_t CFG_DIV_MULT  = 2'd0;
  localparam cfg_addr_t CFG_MAX_DELAY = 2'd1;
  localparam cfg_addr_t CFG_TIMEOUT   = 2'd2;

  localparam logic [16:0] MULT_RESET      = 17'd65536;
  localparam logic [10:0] MAX_DELAY_RESET = 11'd1291;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd2091;

  // Microcode.
  typedef enum logic [2:0] {
    UOP_ACCEPT,
    UOP_MUL,
    UOP_UPDATE,
    UOP_SEARCH,
    UOP_FINISH,
    UOP_NOP
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_EVENT,
    COND_BITS_LEFT,
    COND_OUT_BUSY
  } cond_t;

  typedef logic [2:0] upc_t;

  localparam upc_t UPC_ACCEPT = 3'd0;
  localparam upc_t UPC_MUL    = 3'd1;
  localparam upc_t UPC_UPDATE = 3'd2;
  localparam upc_t UPC_SEARCH = 3'd3;
  localparam upc_t UPC_FINISH = 3'd4;
  localparam upc_t UPC_RETURN = 3'd5;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  localparam int UCODE_DEPTH = 8;

  // A taken condition jumps to the target, otherwise the counter steps on.
  localparam uword_t UCODE [UCODE_DEPTH] = '{
    '{UOP_ACCEPT, COND_NO_EVENT,  UPC_ACCEPT},
    '{UOP_MUL,    COND_NEVER,     UPC_ACCEPT},
    '{UOP_UPDATE, COND_NEVER,     UPC_ACCEPT},
    '{UOP_SEARCH, COND_BITS_LEFT, UPC_SEARCH},
    '{UOP_FINISH, COND_OUT_BUSY,  UPC_FINISH},
    '{UOP_NOP,    COND_ALWAYS,    UPC_ACCEPT},
    '{UOP_NOP,    COND_ALWAYS,    UPC_ACCEPT},
    '{UOP_NOP,    COND_ALWAYS,    UPC_ACCEPT}
  };

  // Tempo table, delay in milliseconds for each wiper step.
  localparam int TBL_ENTRIES = 256;
  typedef logic [10:0] tbl_entry_t;

  localparam tbl_entry_t WIPER_TABLE [TBL_ENTRIES] = '{
    11'd51, 11'd52, 11'd54, 11'd59, 11'd65, 11'd71, 11'd77, 11'd83,
    11'd89, 11'd94, 11'd99, 11'd105, 11'd110, 11'd115, 11'd120, 11'd125,
    11'd131, 11'd136, 11'd141, 11'd146, 11'd152, 11'd157, 11'd162, 11'd168,
    11'd173, 11'd179, 11'd185, 11'd190, 11'd196, 11'd201, 11'd206, 11'd211,
    11'd217, 11'd222, 11'd227, 11'd232, 11'd237, 11'd242, 11'd247, 11'd252,
    11'd257, 11'd262, 11'd267, 11'd272, 11'd277, 11'd282, 11'd287, 11'd292,
    11'd298, 11'd302, 11'd307, 11'd312, 11'd317, 11'd322, 11'd327, 11'd332,
    11'd338, 11'd343, 11'd348, 11'd353, 11'd359, 11'd364, 11'd369, 11'd374,
    11'd379, 11'd384, 11'd389, 11'd394, 11'd399, 11'd405, 11'd410, 11'd415,
    11'd420, 11'd425, 11'd430, 11'd435, 11'd439, 11'd444, 11'd449, 11'd454,
    11'd459, 11'd464, 11'd469, 11'd474, 11'd479, 11'd484, 11'd488, 11'd493,
    11'd498, 11'd503, 11'd507, 11'd512, 11'd517, 11'd522, 11'd527, 11'd532,
    11'd537, 11'd542, 11'd547, 11'd551, 11'd556, 11'd561, 11'd566, 11'd571,
    11'd576, 11'd581, 11'd586, 11'd591, 11'd596, 11'd601, 11'd606, 11'd611,
    11'd615, 11'd620, 11'd625, 11'd630, 11'd635, 11'd640, 11'd645, 11'd650,
    11'd655, 11'd660, 11'd664, 11'd669, 11'd674, 11'd679, 11'd684, 11'd688,
    11'd693, 11'd698, 11'd703, 11'd708, 11'd713, 11'd718, 11'd722, 11'd727,
    11'd732, 11'd737, 11'd741, 11'd746, 11'd750, 11'd755, 11'd760, 11'd765,
    11'd770, 11'd775, 11'd779, 11'd784, 11'd789, 11'd794, 11'd798, 11'd803,
    11'd808, 11'd812, 11'd817, 11'd822, 11'd827, 11'd831, 11'd836, 11'd841,
    11'd846, 11'd850, 11'd855, 11'd860, 11'd865, 11'd869, 11'd874, 11'd879,
    11'd884, 11'd888, 11'd893, 11'd898, 11'd903, 11'd908, 11'd912, 11'd917,
    11'd922, 11'd926, 11'd931, 11'd936, 11'd941, 11'd945, 11'd950, 11'd955,
    11'd960, 11'd965, 11'd969, 11'd974, 11'd979, 11'd983, 11'd988, 11'd993,
    11'd997, 11'd1002, 11'd1007, 11'd1012, 11'd1017, 11'd1021, 11'd1026, 11'd1031,
    11'd1036, 11'd1040, 11'd1045, 11'd1049, 11'd1054, 11'd1058, 11'd1063, 11'd1068,
    11'd1073, 11'd1078, 11'd1082, 11'd1087, 11'd1092, 11'd1097, 11'd1101, 11'd1106,
    11'd1110, 11'd1115, 11'd1120, 11'd1124, 11'd1129, 11'd1133, 11'd1138, 11'd1142,
    11'd1147, 11'd1152, 11'd1157, 11'd1162, 11'd1166, 11'd1171, 11'd1175, 11'd1180,
    11'd1185, 11'd1189, 11'd1194, 11'd1199, 11'd1203, 11'd1208, 11'd1212, 11'd1217,
    11'd1222, 11'd1226, 11'd1231, 11'd1236, 11'd1241, 11'd1245, 11'd1250, 11'd1254,
    11'd1259, 11'd1264, 11'd1268, 11'd1273, 11'd1277, 11'd1282, 11'd1287, 11'd1291
  };

endpackage

// ===== hw/rtl/tap_tempo_to_wiper.sv =====
// ----------------------------------------------------------------------------
// Tap tempo to wiper position
// Measures the time between button taps, averages it into a tempo and maps
// the divided tempo onto the nearest step of the delay tempo table.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Word
//   in_      input      in_valid / in_stall  button level, millisecond tick
//   out_     output     out_valid/out_stall  event kind, wiper, beat, divided
//   cfg_     input      cfg_we               multiplier, clamp, timeout
//
// A word that causes no result leaves the sequencer in its accept step, and
// the next word can follow in the next cycle.
// A word that causes a result runs through the accepting step, one multiply,
// one update, one table search step per index bit, a step to form the result
// and one to return to the accept step. The input is stalled in all of these
// steps but the first.
// Reset is synchronous and active low; it restores the register defaults and
// clears the tap sequence. There is no clearing pass.
// When the result register is still held by a stall, the sequencer waits in
// its result step with the input stalled until the register is free.
//
module tap_tempo_to_wiper #(
  parameter int TABLE_DEPTH = 256,
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ttw_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ttw_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  ttw_pkg::cfg_addr_t cfg_addr,
  input  ttw_pkg::cfg_data_t cfg_wdata
);
  import ttw_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int MULT_W  = 17;
  localparam int PROD_W  = COUNT_WIDTH + MULT_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int CMP_W   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int BSUM_W  = CMP_W + 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] TOP_BIT  = IDX_W'(1) << (IDX_W - 1);

  // Tap sequence position: nothing armed, armed by the first press, or
  // at least one tempo already set.
  localparam logic [1:0] TAP_NONE = 2'd0;
  localparam logic [1:0] TAP_ONE  = 2'd1;
  localparam logic [1:0] TAP_MANY = 2'd2;

  // Configuration registers.
  logic [16:0] mult_r;
  logic [10:0] max_delay_r;
  logic [15:0] timeout_r;

  // Sequence state.
  logic [COUNT_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [1:0]             tap_r, tap_nxt;
  logic                   down_r, down_nxt;
  logic [15:0]            beat_r, beat_nxt;
  logic [10:0]            div_r, div_nxt;

  // Sequencer and datapath.
  upc_t                   pc_r, pc_nxt;
  uword_t                 uw;
  logic                   kind_r, kind_nxt;
  logic                   first_r, first_nxt;
  logic [COUNT_WIDTH-1:0] snap_r, snap_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [IDX_W-1:0]       bit_r, bit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_data_r, out_data_nxt;

  logic in_acc;
  logic event_now;
  logic out_free;
  logic take_jump;

  assign uw       = UCODE[pc_r];
  assign in_stall = (uw.op != UOP_ACCEPT);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r      <= MULT_RESET;
      max_delay_r <= MAX_DELAY_RESET;
      timeout_r   <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DIV_MULT:  mult_r      <= cfg_wdata;
        CFG_MAX_DELAY: max_delay_r <= cfg_wdata[10:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_wdata[15:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= UPC_ACCEPT;
      out_valid_r <= 1'b0;
      elapsed_r   <= '0;
      tap_r       <= TAP_NONE;
      down_r      <= 1'b0;
      beat_r      <= '0;
      div_r       <= '0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      elapsed_r   <= elapsed_nxt;
      tap_r       <= tap_nxt;
      down_r      <= down_nxt;
      beat_r      <= beat_nxt;
      div_r       <= div_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    first_r    <= first_nxt;
    snap_r     <= snap_nxt;
    prod_r     <= prod_nxt;
    idx_r      <= idx_nxt;
    bit_r      <= bit_nxt;
    out_data_r <= out_data_nxt;
  end

  // Datapath controlled by the current control word.
  always_comb begin
    logic [COUNT_WIDTH-1:0] e_tick, e_first, e_tmo;
    logic [1:0]             t_first, t_tmo;
    logic                   d_first, d_rel;
    logic                   press, tick, arm, timeout_hit, later;
    logic [SUM_W-1:0]       d_sum;
    logic [BSUM_W-1:0]      b_sum;
    logic [IDX_W-1:0]       cand, k_idx, near_idx, wiper_idx;
    logic                   at_low, at_high;

    elapsed_nxt   = elapsed_r;
    tap_nxt       = tap_r;
    down_nxt      = down_r;
    beat_nxt      = beat_r;
    div_nxt       = div_r;
    kind_nxt      = kind_r;
    first_nxt     = first_r;
    snap_nxt      = snap_r;
    prod_nxt      = prod_r;
    idx_nxt       = idx_r;
    bit_nxt       = bit_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    event_now     = 1'b0;

    // Word bookkeeping, in the order tick, first press, timeout, release,
    // later press.
    press   = in_data.button_pressed;
    tick    = in_data.ms_tick;
    e_tick  = (tick && (elapsed_r != '1)) ? elapsed_r + 1'b1 : elapsed_r;
    arm     = press && !down_r && (tap_r == TAP_NONE);
    e_first = arm ? '0 : e_tick;
    t_first = arm ? TAP_ONE : tap_r;
    d_first = down_r || arm;
    timeout_hit = (CMP_W'(e_first) > CMP_W'(timeout_r)) && !press && !d_first;
    e_tmo   = timeout_hit ? '0 : e_first;
    t_tmo   = timeout_hit ? TAP_NONE : t_first;
    d_rel   = press ? d_first : 1'b0;
    later   = press && !d_rel && (t_tmo != TAP_NONE);

    // Tempo arithmetic on the registered product.
    if (first_r) begin
      d_sum = SUM_W'(prod_r >> 16);
      b_sum = BSUM_W'(snap_r);
    end else begin
      d_sum = (SUM_W'({div_r, 16'd0}) + SUM_W'(prod_r) + SUM_W'(17'h10000)) >> 17;
      b_sum = (BSUM_W'(beat_r) + BSUM_W'(snap_r)) >> 1;
    end

    // Nearest table entry: idx_r holds the last entry below the tempo.
    cand     = idx_r | bit_r;
    k_idx    = idx_r + 1'b1;
    at_low   = div_r <= WIPER_TABLE[0];
    at_high  = div_r >= WIPER_TABLE[8'(LAST_IDX)];
    near_idx = ((div_r - WIPER_TABLE[8'(idx_r)]) >= (WIPER_TABLE[8'(k_idx)] - div_r))
               ? k_idx : idx_r;
    if (at_low) begin
      wiper_idx = '0;
    end else if (at_high) begin
      wiper_idx = LAST_IDX;
    end else begin
      wiper_idx = near_idx;
    end

    unique case (uw.op)
      UOP_ACCEPT: begin
        if (in_acc) begin
          event_now   = timeout_hit || later;
          elapsed_nxt = later ? '0 : e_tmo;
          tap_nxt     = later ? TAP_MANY : t_tmo;
          down_nxt    = later ? 1'b1 : d_rel;
          kind_nxt    = later ? EVENT_TAP : EVENT_SAVE;
          first_nxt   = (t_tmo == TAP_ONE);
          snap_nxt    = e_tmo;
        end
      end
      UOP_MUL: begin
        prod_nxt = PROD_W'(snap_r) * PROD_W'(mult_r);
      end
      UOP_UPDATE: begin
        if (kind_r == EVENT_TAP) begin
          div_nxt  = (d_sum > SUM_W'(max_delay_r)) ? max_delay_r : d_sum[10:0];
          beat_nxt = (b_sum > BSUM_W'(16'hFFFF)) ? 16'hFFFF : b_sum[15:0];
        end
        idx_nxt = '0;
        bit_nxt = TOP_BIT;
      end
      UOP_SEARCH: begin
        if ((cand <= LAST_IDX) && (WIPER_TABLE[8'(cand)] < div_r)) begin
          idx_nxt = cand;
        end
        bit_nxt = bit_r >> 1;
      end
      UOP_FINISH: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.event_kind     = kind_r;
          out_data_nxt.wiper_position = 8'(wiper_idx);
          out_data_nxt.beat_ms        = beat_r;
          out_data_nxt.divided_ms     = div_r;
        end
      end
      UOP_NOP: ;
      default: ;
    endcase
  end

  // Step counter.
  always_comb begin
    unique case (uw.cond)
      COND_NEVER:     take_jump = 1'b0;
      COND_ALWAYS:    take_jump = 1'b1;
      COND_NO_EVENT:  take_jump = !event_now;
      COND_BITS_LEFT: take_jump = !bit_r[0];
      COND_OUT_BUSY:  take_jump = !out_free;
      default:        take_jump = 1'b1;
    endcase
    pc_nxt = take_jump ? uw.target : pc_r + 1'b1;
  end

endmodule

// ===== hw/rtl/ttw_chk.sv =====
// ----------------------------------------------------------------------------
// Tap tempo port checker
// Checks the tap tempo block's result channel as seen at its ports.
// ----------------------------------------------------------------------------
`include "tap_tempo_to_wiper_macros.svh"

module ttw_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ttw_pkg::out_word_t out_data
);
  import ttw_pkg::*;

  logic out_held;
  logic low_tempo;

  assign out_held  = rst_n && out_valid && out_stall;
  assign low_tempo = out_valid && (out_data.divided_ms <= WIPER_TABLE[0]);

  // A stalled result word stays put.
  `TTW_ASSERT_NEXT(a_out_hold, clk, out_held, out_valid && $stable(out_data))

  // Reset empties the result register.
  `TTW_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid)

  // A new result is only formed while the input side is held off.
  `TTW_ASSERT_NOW(a_rise_busy, clk, rst_n, $rose(out_valid) && in_valid, $past(in_stall))

  // Tempos at or below the shortest table delay select the first wiper step.
  `TTW_ASSERT_NOW(a_low_end, clk, rst_n, low_tempo, out_data.wiper_position == 8'd0)

endmodule

bind tap_tempo_to_wiper ttw_chk u_ttw_chk (.*);
